// File: src/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swm_pkg: shared definitions for the sliding window median filter
// Register width and reset value, parameter defaults, and the small structs
// that pass between the sorted cells and the top level.
// ============================================================================
package swm_pkg;

   localparam int WIN_LEN_W = 7;
   localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 7'd3;

   localparam int MAX_WINDOW_DEF = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // Broadcast to every cell of the sorted chain.
   typedef struct packed {
      logic load;     // an item is taken in this cycle
      logic remove;   // the window is full, so the oldest key leaves
   } swm_ctrl_type;

   // What one cell tells its neighbors about its current key.
   typedef struct packed {
      logic bound;    // no cell here: below the bottom of the chain
      logic gt;       // empty, or key above the incoming key
      logic eq;       // holds a key equal to the departing key
   } swm_link_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SETTLE = 2'b10
   } swm_state_type;

endpackage : swm_pkg
`default_nettype wire

// File: src/swm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swm_cell: one slot of the sorted chain
// Holds one key and, per item, takes its new key from itself, a neighbor or
// the incoming key, so that the chain stays sorted after a remove and insert.
// ============================================================================
module swm_cell
   import swm_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire swm_ctrl_type          ctrl,
   input  wire logic                  valid,
   input  wire logic [DATA_WIDTH-1:0] new_key,
   input  wire logic [DATA_WIDTH-1:0] old_key,
   input  wire logic [DATA_WIDTH-1:0] lo_key,
   input  wire swm_link_type          lo_link,
   input  wire logic [DATA_WIDTH-1:0] hi_key,
   input  wire swm_link_type          hi_link,
   output logic      [DATA_WIDTH-1:0] key,
   output swm_link_type               link
);

   logic [DATA_WIDTH-1:0] key_ff;
   logic [DATA_WIDTH-1:0] key_in;
   logic                  gt_self;
   logic                  gtold_self;
   logic                  eq_self;
   logic                  rem_le;
   logic                  rem_lt;
   logic [DATA_WIDTH-1:0] b_self_key;
   logic                  b_self_gt;
   logic [DATA_WIDTH-1:0] b_lo_key;
   logic                  b_lo_gt;

   always_comb begin
      gt_self    = !valid || (key_ff > new_key);
      gtold_self = !valid || (key_ff > old_key);
      eq_self    = valid && (key_ff == old_key);

      // Equal keys sit oldest first, so the departing entry is the lowest
      // cell holding the departing key.
      rem_le = ctrl.remove && (gtold_self || eq_self);
      rem_lt = ctrl.remove &&
               (gtold_self || (eq_self && lo_link.eq && !lo_link.bound));

      // Contents of this slot and the one below once the oldest is gone.
      if (rem_le) begin
         b_self_key = hi_key;
         b_self_gt  = hi_link.gt;
      end else begin
         b_self_key = key_ff;
         b_self_gt  = gt_self;
      end
      if (rem_lt) begin
         b_lo_key = key_ff;
         b_lo_gt  = gt_self;
      end else begin
         b_lo_key = lo_key;
         b_lo_gt  = lo_link.gt && !lo_link.bound;
      end

      // The incoming key goes above every key that is not greater.
      if (b_lo_gt) begin
         key_in = b_lo_key;
      end else if (b_self_gt) begin
         key_in = new_key;
      end else begin
         key_in = b_self_key;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         key_ff <= key_in;
      end
   end

   assign key        = key_ff;
   assign link.bound = 1'b0;
   assign link.gt    = gt_self;
   assign link.eq    = eq_self;

endmodule : swm_cell
`default_nettype wire

// File: src/swm_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// swm_chain: the row of sorted cells
// Wires each cell to its neighbors and marks the cells below the fill count
// as holding part of the window.
// ============================================================================
module swm_chain
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int LEN_W     = $clog2(MAX_WINDOW + 1)
) (
   input  wire logic                                  clock,
   input  wire swm_ctrl_type                          ctrl,
   input  wire logic [LEN_W-1:0]                      fill,
   input  wire logic [DATA_WIDTH-1:0]                 new_key,
   input  wire logic [DATA_WIDTH-1:0]                 old_key,
   output logic      [MAX_WINDOW-1:0][DATA_WIDTH-1:0] cell_keys
);

   localparam swm_link_type BOTTOM_LINK = '{bound: 1'b1, gt: 1'b0, eq: 1'b0};
   localparam swm_link_type TOP_LINK    = '{bound: 1'b0, gt: 1'b1, eq: 1'b0};

   swm_link_type links [MAX_WINDOW];

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lo_key;
      swm_link_type          lo_link;
      logic [DATA_WIDTH-1:0] hi_key;
      swm_link_type          hi_link;
      logic                  valid;

      if (i == 0) begin : g_bottom
         assign lo_key  = '0;
         assign lo_link = BOTTOM_LINK;
      end else begin : g_lower
         assign lo_key  = cell_keys[i-1];
         assign lo_link = links[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_top
         assign hi_key  = '0;
         assign hi_link = TOP_LINK;
      end else begin : g_upper
         assign hi_key  = cell_keys[i+1];
         assign hi_link = links[i+1];
      end

      assign valid = fill > LEN_W'(i);

      swm_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .valid   (valid),
         .new_key (new_key),
         .old_key (old_key),
         .lo_key  (lo_key),
         .lo_link (lo_link),
         .hi_key  (hi_key),
         .hi_link (hi_link),
         .key     (cell_keys[i]),
         .link    (links[i])
      );
   end

endmodule : swm_chain
`default_nettype wire

// File: src/sliding_window_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sliding_window_median: streaming lower-median filter over a sliding window
// Keeps the last window_len samples in a delay ring and in a sorted cell chain
// and returns the lower median of each full window.
// ============================================================================
// Each item on the req_ side carries one signed sample. The block keeps the
// most recent window_len samples, duplicates included, and once that many
// samples have arrived every item yields one result item: the lower median,
// the element of rank ceil(window_len/2) in ascending order. Items before the
// window has filled yield no result. As an item is taken in ST_IDLE, the
// sorted chain of MAX_WINDOW cells drops the oldest sample and inserts the new
// one in a single step. The item then moves to ST_SETTLE, staying there while
// its own result waits for an untaken earlier one; there the delay ring memory
// delivers the next departing sample through its registered read port while
// the median is picked from the chain into the output register. A new item is
// taken while an earlier result still waits on the rsp_ side; the block only
// holds off for the output when a second result would overwrite an untaken
// one. Writing window_len empties the window, so results resume after
// window_len new samples. A window write offered in the same cycle as a sample
// goes first, and the sample waits. A value of zero acts as one and values
// above MAX_WINDOW act as MAX_WINDOW. There is no clearing pass after reset.
// ============================================================================
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int BUS_W     = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Sample input.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [BUS_W-1:0]     req_tdata,   // [DATA_WIDTH-1:0] sample_value
   // Median output.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [BUS_W-1:0]     rsp_tdata,   // [DATA_WIDTH-1:0] median_value
   // Window length register.
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [WIN_LEN_W-1:0] csr_data
);

   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic [DATA_WIDTH-1:0] SIGN_MASK = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

   // Window length actually used for a register value.
   function automatic logic [LEN_W-1:0] clamp_len(input logic [WIN_LEN_W-1:0] value);
      logic [LEN_W-1:0] len;
      if (value == '0) begin
         len = LEN_W'(1);
      end else if (32'(value) > MAX_WINDOW) begin
         len = LEN_W'(MAX_WINDOW);
      end else begin
         len = LEN_W'(value);
      end
      return len;
   endfunction

   // Cell index of the lower median: ceil(len/2) - 1.
   function automatic logic [PTR_W-1:0] median_index(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] idx;
      idx = (len - LEN_W'(1)) >> 1;
      return PTR_W'(idx);
   endfunction

   localparam logic [LEN_W-1:0] RESET_LEN = clamp_len(WIN_LEN_RESET);
   localparam logic [PTR_W-1:0] RESET_MED = median_index(RESET_LEN);

   swm_state_type                  state_ff, state_in;
   logic [LEN_W-1:0]               len_ff, len_in;
   logic [PTR_W-1:0]               med_idx_ff, med_idx_in;
   logic [LEN_W-1:0]               fill_ff, fill_in;
   logic [PTR_W-1:0]               ptr_ff, ptr_in;
   logic                           emit_ff, emit_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]          rsp_data_ff, rsp_data_in;
   logic [DATA_WIDTH-1:0]          old_key_ff;
   logic [DATA_WIDTH-1:0]          ring_mem [MAX_WINDOW];

   logic                           req_accept;
   logic                           csr_write;
   logic                           full;
   logic                           out_free;
   logic [LEN_W-1:0]               ptr_inc;
   logic [DATA_WIDTH-1:0]          new_key;
   swm_ctrl_type                   chain_ctrl;
   logic [MAX_WINDOW-1:0][DATA_WIDTH-1:0] cell_keys;

   // A pending window write holds off the sample side for that cycle.
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_valid && csr_ready;

   // Flipping the sign bit turns signed order into unsigned order.
   assign new_key = req_tdata[DATA_WIDTH-1:0] ^ SIGN_MASK;
   assign full    = (fill_ff == len_ff);
   assign ptr_inc = LEN_W'(ptr_ff) + LEN_W'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign chain_ctrl.load   = req_accept;
   assign chain_ctrl.remove = full;

   swm_chain #(
      .MAX_WINDOW (MAX_WINDOW),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .fill      (fill_ff),
      .new_key   (new_key),
      .old_key   (old_key_ff),
      .cell_keys (cell_keys)
   );

   // Delay ring. The read runs every cycle at the oldest slot, so the key
   // that leaves on the next item is ready in the cycle after the pointer moves.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ring_mem[ptr_ff] <= new_key;
      end
      old_key_ff <= ring_mem[ptr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      med_idx_in   = med_idx_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               len_in     = clamp_len(csr_data);
               med_idx_in = median_index(clamp_len(csr_data));
               fill_in    = '0;
               ptr_in     = '0;
            end else if (req_accept) begin
               // The window is full after this item if it was already full
               // or if this sample completes it.
               emit_in  = full || ((fill_ff + LEN_W'(1)) == len_ff);
               fill_in  = full ? fill_ff : fill_ff + LEN_W'(1);
               ptr_in   = (ptr_inc >= len_ff) ? '0 : PTR_W'(ptr_inc);
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            // The chain now holds the new window. An item with a result
            // waits here until the output register has room.
            if (out_free || !emit_ff) begin
               if (emit_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = cell_keys[med_idx_ff] ^ SIGN_MASK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= RESET_LEN;
         med_idx_ff   <= RESET_MED;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         med_idx_ff   <= med_idx_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = BUS_W'(rsp_data_ff);

   // The window never holds more samples than its length.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= len_ff)
      else $error("fill count above window length");

   // The oldest-sample pointer stays inside the active window.
   assert property (@(posedge clock) disable iff (reset) LEN_W'(ptr_ff) < len_ff)
      else $error("ring pointer outside window");

   // A result appears only as the settle cycle of an item ends.
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid_ff) |-> $past(state_ff == ST_SETTLE))
      else $error("result without a settled item");

   // An item that completes a full window always leaves a result behind.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_SETTLE && emit_ff && out_free) |=> rsp_valid_ff)
      else $error("full window item lost its result");

endmodule : sliding_window_median
`default_nettype wire
